// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers for the RTL files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled while in reset.
`define KS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk_i and disabled while in reset.
`define KS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hw/rtl/kstep_pkg.sv -----
package kstep_pkg;

  // Problem size and number format.
  localparam int STATE_DIM = 4;
  localparam int FRAC_BITS = 16;
  localparam int COV_LEN   = STATE_DIM * STATE_DIM;
  localparam int NUM_GAINS = 6;
  localparam int IDX_W     = (STATE_DIM > 1) ? $clog2(STATE_DIM) : 1;
  localparam int COV_W     = (COV_LEN > 1) ? $clog2(COV_LEN) : 1;
  localparam int GAIN_W    = $clog2(NUM_GAINS);
  localparam int IT_W      = $clog2(FRAC_BITS + 1);

  // ln 2 in Q30 and the clamp on the normalised innovation square.
  localparam logic signed [31:0] LN2_Q30  = 32'sd744261118;
  localparam logic [40:0]        ZZ_CLAMP = 41'h100_0000_0000;

  // Input item kinds.
  localparam logic [2:0] KIND_MEAN  = 3'd0;
  localparam logic [2:0] KIND_COV   = 3'd1;
  localparam logic [2:0] KIND_TRANS = 3'd2;
  localparam logic [2:0] KIND_PNOISE = 3'd3;
  localparam logic [2:0] KIND_ONOISE = 3'd4;
  localparam logic [2:0] KIND_OBS   = 3'd5;

  // Result item kinds.
  localparam logic [1:0] OKIND_MEAN   = 2'd0;
  localparam logic [1:0] OKIND_COV    = 2'd1;
  localparam logic [1:0] OKIND_WEIGHT = 2'd2;

  typedef struct packed {
    logic [2:0]         kind;
    logic [5:0]         elem_index;
    logic signed [31:0] value;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         out_kind;
    logic [5:0]         out_index;
    logic signed [31:0] out_value;
    logic               out_last;
  } out_item_t;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) begin
      return 32'sh7fff_ffff;
    end else if (x < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return x[31:0];
  endfunction

  // Round an exact product to FRAC_BITS fraction bits, half up.
  function automatic logic signed [63:0] fround(input logic signed [63:0] x);
    return (x + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

endpackage

// ----- hw/rtl/kstep_mul.sv -----
module kstep_mul (
  input  logic               clk_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic signed [63:0] prod_o
);

  // Exact product, registered.
  always_ff @(posedge clk_i) begin
    prod_o <= 64'(a_i) * 64'(b_i);
  end

endmodule

// ----- hw/rtl/kstep_div.sv -----
module kstep_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quot_o
);

  logic        busy_q;
  logic [5:0]  cnt_q;
  logic        done_q;
  logic [31:0] rem_q;
  logic [63:0] quo_q;
  logic [31:0] dsr_q;
  logic [32:0] sh;
  logic        fit;

  // One quotient bit a cycle, restoring.
  assign sh  = {rem_q, quo_q[63]};
  assign fit = (sh >= {1'b0, dsr_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fit ? 32'(sh - {1'b0, dsr_q}) : sh[31:0];
      quo_q <= {quo_q[62:0], fit};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ----- hw/rtl/kalman_step_diag_scalar_obs.sv -----
// Kalman predict and update for one particle with a diagonal transition,
// diagonal process noise and a scalar observation, in signed Q16.16.
// Operand items load at one per cycle while the block is idle; the item
// marked last starts the computation and the block stalls its input until
// the log weight has been taken. The computation runs on one registered
// 32x32 multiplier (5s^2 + 4s + 18 products for dimension s) and one
// 64-step bit-serial divider (up to s + 1 divisions), plus a leading-one
// normalisation for the logarithm. The block offers s + s^2 + 1 results:
// the s mean results, the s^2 covariance results and the log weight.
module kalman_step_diag_scalar_obs (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  kstep_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output kstep_pkg::out_item_t out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  import kstep_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MUP, ST_FP1, ST_FP2, ST_PHT, ST_HP, ST_SS, ST_Z, ST_KDIV,
    ST_EMEAN, ST_ECOV, ST_OWAIT, ST_ZZ, ST_QDIV, ST_NORM, ST_SQ, ST_LN
  } state_e;

  state_e state_q, state_d;
  logic [IDX_W-1:0] j_q, j_d, k_q, k_d;
  logic             ph_q, ph_d;
  logic [IT_W-1:0]  it_q, it_d;
  logic             oval_q, oval_d;
  out_item_t        out_q, out_d;

  logic signed [31:0] gain_q [NUM_GAINS];
  logic signed [31:0] mean_q [STATE_DIM];
  logic signed [31:0] cov_q  [COV_LEN];
  logic signed [31:0] fd_q   [STATE_DIM];
  logic signed [31:0] qn_q   [STATE_DIM];
  logic signed [31:0] pc_q   [COV_LEN];
  logic signed [31:0] kg_q   [STATE_DIM];
  logic signed [31:0] mup_q  [STATE_DIM];
  logic signed [31:0] pht_q  [STATE_DIM];
  logic signed [31:0] hp_q   [STATE_DIM];
  logic signed [31:0] r_q, y_q;
  logic signed [31:0] t_q, t_d, s_q, s_d, z_q, z_d;
  logic signed [63:0] acc_q, acc_d;
  logic [31:0]        m_q, m_d;
  logic [4:0]         p_q, p_d;
  logic [FRAC_BITS-1:0] frac_q, frac_d;
  logic [40:0]        q_q, q_d;

  logic               we_mup, we_pc, we_pht, we_hp, we_kg;
  logic signed [31:0] wval;
  logic               last_j, last_k, s_pos, in_acc;
  logic [COV_W-1:0]   jk, kj, pc_addr;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p, rnd, accn, lnv, wsum;
  logic signed [31:0] v32, l2;
  logic [31:0]        sq;
  logic [63:0]        num, div_dvd;
  logic               div_start, div_done;
  logic [63:0]        div_quot;
  logic signed [63:0] qs;
  logic [2:0]         cidx;

  assign in_acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign last_j = (j_q == IDX_W'(STATE_DIM - 1));
  assign last_k = (k_q == IDX_W'(STATE_DIM - 1));
  assign s_pos  = (s_q > 32'sd0);
  assign jk     = COV_W'(32'(j_q) * STATE_DIM + 32'(k_q));
  assign kj     = COV_W'(32'(k_q) * STATE_DIM + 32'(j_q));
  assign pc_addr = (state_q == ST_HP) ? kj : jk;
  assign rnd    = fround(mul_p);
  assign l2     = $signed(32'((32'(p_q) - 32'(FRAC_BITS)) << FRAC_BITS) + 32'(frac_q));
  assign sq     = mul_p[61:30];

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = fd_q[j_q];
    mul_b = mean_q[j_q];
    case (state_q)
      ST_FP1:   mul_b = cov_q[jk];
      ST_FP2:   begin mul_a = t_q; mul_b = fd_q[k_q]; end
      ST_PHT:   begin mul_a = pc_q[pc_addr]; mul_b = gain_q[GAIN_W'(k_q)]; end
      ST_HP:    begin mul_a = gain_q[GAIN_W'(k_q)]; mul_b = pc_q[pc_addr]; end
      ST_SS:    begin mul_a = gain_q[GAIN_W'(j_q)]; mul_b = pht_q[j_q]; end
      ST_Z:     begin mul_a = gain_q[GAIN_W'(j_q)]; mul_b = mup_q[j_q]; end
      ST_EMEAN: begin mul_a = kg_q[j_q]; mul_b = z_q; end
      ST_ECOV:  begin mul_a = kg_q[j_q]; mul_b = hp_q[k_q]; end
      ST_ZZ:    begin mul_a = z_q; mul_b = z_q; end
      ST_SQ:    begin mul_a = $signed(m_q); mul_b = $signed(m_q); end
      ST_LN:    begin mul_a = l2; mul_b = LN2_Q30; end
      default:  ;
    endcase
  end

  // Dividend for the gain or for the innovation term, with half the divisor added.
  always_comb begin
    num = (pht_q[j_q] < 32'sd0) ? 64'(-64'(pht_q[j_q])) : 64'(64'(pht_q[j_q]));
    if (state_q == ST_QDIV) begin
      div_dvd = 64'(acc_q) + {33'b0, s_q[31:1]};
    end else begin
      div_dvd = (num << FRAC_BITS) + {33'b0, s_q[31:1]};
    end
  end

  kstep_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (mul_p)
  );

  kstep_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (s_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Sequencer: each product is issued in phase zero and used in phase one.
  always_comb begin
    state_d = state_q;
    j_d = j_q;
    k_d = k_q;
    ph_d = ph_q;
    it_d = it_q;
    oval_d = oval_q;
    out_d = out_q;
    t_d = t_q;
    s_d = s_q;
    z_d = z_q;
    acc_d = acc_q;
    m_d = m_q;
    p_d = p_q;
    frac_d = frac_q;
    q_d = q_q;
    we_mup = 1'b0;
    we_pc = 1'b0;
    we_pht = 1'b0;
    we_hp = 1'b0;
    we_kg = 1'b0;
    wval = '0;
    div_start = 1'b0;
    accn = ((state_q == ST_SS || state_q == ST_Z) ? (j_q == '0) : (k_q == '0))
           ? rnd : acc_q + rnd;
    v32 = sat32(rnd);
    qs = $signed(div_quot);
    lnv = (mul_p + (64'sd1 <<< 29)) >>> 30;
    wsum = -(lnv + 64'(q_q));
    case (state_q)
      ST_IDLE: begin
        if (in_acc && in_data_i.last) begin
          state_d = ST_MUP;
          j_d = '0;
          k_d = '0;
          ph_d = 1'b0;
        end
      end
      ST_MUP: begin
        ph_d = !ph_q;
        if (ph_q) begin
          we_mup = 1'b1;
          wval = v32;
          if (last_j) begin
            j_d = '0;
            state_d = ST_FP1;
          end else begin
            j_d = j_q + 1'b1;
          end
        end
      end
      ST_FP1: begin
        ph_d = !ph_q;
        if (ph_q) begin
          t_d = v32;
          state_d = ST_FP2;
        end
      end
      ST_FP2: begin
        ph_d = !ph_q;
        if (ph_q) begin
          we_pc = 1'b1;
          wval = (j_q == k_q) ? sat32(64'(v32) + 64'(qn_q[j_q])) : v32;
          state_d = ST_FP1;
          if (last_k) begin
            k_d = '0;
            if (last_j) begin
              j_d = '0;
              state_d = ST_PHT;
            end else begin
              j_d = j_q + 1'b1;
            end
          end else begin
            k_d = k_q + 1'b1;
          end
        end
      end
      ST_PHT, ST_HP: begin
        ph_d = !ph_q;
        if (ph_q) begin
          acc_d = accn;
          if (last_k) begin
            we_pht = (state_q == ST_PHT);
            we_hp = (state_q == ST_HP);
            wval = sat32(accn);
            k_d = '0;
            if (last_j) begin
              j_d = '0;
              state_d = (state_q == ST_PHT) ? ST_HP : ST_SS;
            end else begin
              j_d = j_q + 1'b1;
            end
          end else begin
            k_d = k_q + 1'b1;
          end
        end
      end
      ST_SS, ST_Z: begin
        ph_d = !ph_q;
        if (ph_q) begin
          acc_d = accn;
          if (last_j) begin
            j_d = '0;
            if (state_q == ST_SS) begin
              s_d = sat32(64'(sat32(accn)) + 64'(r_q));
              state_d = ST_Z;
            end else begin
              z_d = sat32(64'(y_q) - 64'(sat32(accn)));
              state_d = ST_KDIV;
            end
          end else begin
            j_d = j_q + 1'b1;
          end
        end
      end
      ST_KDIV: begin
        if (!s_pos || (ph_q && div_done)) begin
          we_kg = 1'b1;
          wval = !s_pos ? 32'sd0 : sat32((pht_q[j_q] < 32'sd0) ? -qs : qs);
          ph_d = 1'b0;
          if (last_j) begin
            j_d = '0;
            state_d = ST_EMEAN;
          end else begin
            j_d = j_q + 1'b1;
          end
        end else if (!ph_q) begin
          div_start = 1'b1;
          ph_d = 1'b1;
        end
      end
      ST_EMEAN, ST_ECOV: begin
        ph_d = !ph_q;
        if (ph_q) begin
          oval_d = 1'b1;
          state_d = ST_OWAIT;
          out_d.out_last = 1'b0;
          if (state_q == ST_EMEAN) begin
            out_d.out_kind = OKIND_MEAN;
            out_d.out_index = 6'(j_q);
            out_d.out_value = sat32(64'(mup_q[j_q]) + rnd);
          end else begin
            out_d.out_kind = OKIND_COV;
            out_d.out_index = 6'(jk);
            out_d.out_value = sat32(64'(pc_q[jk]) - rnd);
          end
        end
      end
      ST_OWAIT: begin
        if (!out_stall_i) begin
          oval_d = 1'b0;
          ph_d = 1'b0;
          case (out_q.out_kind)
            OKIND_MEAN: begin
              if (last_j) begin
                j_d = '0;
                k_d = '0;
                state_d = ST_ECOV;
              end else begin
                j_d = j_q + 1'b1;
                state_d = ST_EMEAN;
              end
            end
            OKIND_COV: begin
              state_d = ST_ECOV;
              if (last_k) begin
                k_d = '0;
                if (last_j) begin
                  j_d = '0;
                  if (s_pos) begin
                    state_d = ST_ZZ;
                  end else begin
                    // Innovation variance not positive: the weight saturates low.
                    state_d = ST_OWAIT;
                    oval_d = 1'b1;
                    out_d.out_kind = OKIND_WEIGHT;
                    out_d.out_index = '0;
                    out_d.out_value = 32'sh8000_0000;
                    out_d.out_last = 1'b1;
                  end
                end else begin
                  j_d = j_q + 1'b1;
                end
              end else begin
                k_d = k_q + 1'b1;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_ZZ: begin
        ph_d = !ph_q;
        if (ph_q) begin
          acc_d = mul_p;
          state_d = ST_QDIV;
        end
      end
      ST_QDIV: begin
        if (!ph_q) begin
          div_start = 1'b1;
          ph_d = 1'b1;
        end else if (div_done) begin
          ph_d = 1'b0;
          q_d = (div_quot > 64'(ZZ_CLAMP)) ? ZZ_CLAMP : div_quot[40:0];
          m_d = s_q;
          p_d = 5'd30;
          state_d = ST_NORM;
        end
      end
      ST_NORM: begin
        // Find the leading one of S, one position a cycle.
        if (m_q[30]) begin
          it_d = '0;
          frac_d = '0;
          ph_d = 1'b0;
          state_d = ST_SQ;
        end else begin
          m_d = {m_q[30:0], 1'b0};
          p_d = p_q - 5'd1;
        end
      end
      ST_SQ: begin
        ph_d = !ph_q;
        if (ph_q) begin
          m_d = sq[31] ? {1'b0, sq[31:1]} : sq;
          frac_d = {frac_q[FRAC_BITS-2:0], sq[31]};
          it_d = it_q + 1'b1;
          if (it_q == IT_W'(FRAC_BITS - 1)) begin
            state_d = ST_LN;
          end
        end
      end
      ST_LN: begin
        ph_d = !ph_q;
        if (ph_q) begin
          oval_d = 1'b1;
          out_d.out_kind = OKIND_WEIGHT;
          out_d.out_index = '0;
          out_d.out_value = sat32((wsum + 64'sd1) >>> 1);
          out_d.out_last = 1'b1;
          state_d = ST_OWAIT;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state, result valid and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      j_q <= '0;
      k_q <= '0;
      ph_q <= 1'b0;
      it_q <= '0;
      oval_q <= 1'b0;
      for (int i = 0; i < NUM_GAINS; i++) begin
        gain_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      j_q <= j_d;
      k_q <= k_d;
      ph_q <= ph_d;
      it_q <= it_d;
      oval_q <= oval_d;
      if (psel && penable && pwrite && (32'(paddr[4:2]) < NUM_GAINS)) begin
        gain_q[paddr[4:2]] <= pwdata;
      end
    end
  end

  // Operand stores and intermediate results.
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    t_q <= t_d;
    s_q <= s_d;
    z_q <= z_d;
    acc_q <= acc_d;
    m_q <= m_d;
    p_q <= p_d;
    frac_q <= frac_d;
    q_q <= q_d;
    if (in_acc) begin
      case (in_data_i.kind)
        KIND_MEAN:
          if (32'(in_data_i.elem_index) < STATE_DIM)
            mean_q[in_data_i.elem_index[IDX_W-1:0]] <= in_data_i.value;
        KIND_COV:
          if (32'(in_data_i.elem_index) < COV_LEN)
            cov_q[in_data_i.elem_index[COV_W-1:0]] <= in_data_i.value;
        KIND_TRANS:
          if (32'(in_data_i.elem_index) < STATE_DIM)
            fd_q[in_data_i.elem_index[IDX_W-1:0]] <= in_data_i.value;
        KIND_PNOISE:
          if (32'(in_data_i.elem_index) < STATE_DIM)
            qn_q[in_data_i.elem_index[IDX_W-1:0]] <= in_data_i.value;
        KIND_ONOISE: r_q <= in_data_i.value;
        KIND_OBS:    y_q <= in_data_i.value;
        default: ;
      endcase
    end
    if (we_mup) mup_q[j_q] <= wval;
    if (we_pc)  pc_q[jk] <= wval;
    if (we_pht) pht_q[j_q] <= wval;
    if (we_hp)  hp_q[j_q] <= wval;
    if (we_kg)  kg_q[j_q] <= wval;
  end

  // Register read-back.
  assign cidx   = paddr[4:2];
  assign prdata = (32'(cidx) < NUM_GAINS) ? gain_q[cidx] : 32'd0;
  assign pready = 1'b1;

  assign out_valid_o = oval_q;
  assign out_data_o  = out_q;

`include "assert_macros.svh"

  // No result is offered while the block takes operand items.
  `KS_ASSERT_IMP(a_idle_no_result, !in_stall_o, !out_valid_o)
  // Only the log weight closes a computation.
  `KS_ASSERT_IMP(a_last_is_weight, out_valid_o && out_data_o.out_last,
                 out_data_o.out_kind == OKIND_WEIGHT)
  // The divider only finishes while the sequencer waits for it.
  `KS_ASSERT_IMP(a_div_owner, div_done, state_q == ST_KDIV || state_q == ST_QDIV)
  // A taken weight returns the block to loading.
  `KS_ASSERT_NXT(a_weight_ends, out_valid_o && !out_stall_i && out_data_o.out_last,
                 !in_stall_o)

endmodule
